@@ hdl/scis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scis_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned MemAw    = $clog2(MemWords);
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_START = 2'd3
  } req_e;

  typedef struct packed {
    req_e        req;
    logic [31:0] addr;
    logic [31:0] wdata;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DEC,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_EXEC,
    ST_TOS,
    ST_TOS_W,
    ST_OUT
  } state_e;

  localparam logic [6:0] ImmMask    = 7'h7F;
  localparam logic [7:0] ImmBit     = 8'h80;
  localparam logic [4:0] OffMask    = 5'h1F;
  localparam logic [4:0] OffFlip    = 5'h10;
  localparam logic [3:0] AddspMask  = 4'hF;
  localparam int unsigned EmuStride = 32;

  localparam logic [7:0] OpPushsp = 8'h02;
  localparam logic [7:0] OpPoppc  = 8'h04;
  localparam logic [7:0] OpAdd    = 8'h05;
  localparam logic [7:0] OpAnd    = 8'h06;
  localparam logic [7:0] OpOr     = 8'h07;
  localparam logic [7:0] OpLoad   = 8'h08;
  localparam logic [7:0] OpNot    = 8'h09;
  localparam logic [7:0] OpFlip   = 8'h0A;
  localparam logic [7:0] OpNop    = 8'h0B;
  localparam logic [7:0] OpStore  = 8'h0C;
  localparam logic [7:0] OpPopsp  = 8'h0D;

  function automatic logic in_range(input logic [31:0] a);
    return ({32'd0, a} < (64'(MemWords) * 64'd4));
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/scis_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ hdl/scis_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scis_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire scis_pkg::cmd_t in_cmd_i,
  output logic               q_valid_o,
  input  wire logic          q_pop_i,
  output scis_pkg::cmd_t     q_cmd_o
);
  import scis_pkg::*;

  // two-entry FIFO between request intake and the executor
  cmd_t     buf_q [QDepth];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ hdl/scis_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scis_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_pop_o,
  input  wire scis_pkg::cmd_t q_cmd_i,
  input  wire logic [31:0]    start_pc_i,
  input  wire logic [31:0]    start_sp_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         read_word_o,
  output logic [31:0]         pc_now_o,
  output logic [31:0]         sp_now_o,
  output logic                idim_now_o,
  output logic                bad_opcode_o
);
  import scis_pkg::*;

  state_e      st_q, st_d;
  logic [31:0] pc_q, pc_d, sp_q, sp_d;
  logic        idim_q, idim_d, bad_q, bad_d;
  cmd_t        cmd_q, cmd_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] a_q, a_d, b_q, b_d;      // operands
  logic [31:0] wa_q, wa_d;              // pending write address
  logic [31:0] rw_q, rw_d;
  logic        wr_q, wr_d;              // pending write valid
  logic        ok_q, ok_d;              // last read address in range

  logic        we;
  logic [31:0] ra;                       // byte address driven at memory
  logic [31:0] wd;
  logic [31:0] rdat;
  logic [31:0] mem_rd;                   // read data masked for range
  logic [MemAw-1:0] ma;

  scis_ram #(.Width(32), .Depth(MemWords)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ma),
    .wdata_i(wd),
    .rdata_o(rdat)
  );

  assign ma     = ra[MemAw+1:2];
  assign mem_rd = ok_q ? rdat : 32'd0;

  assign out_valid_o  = (st_q == ST_OUT);
  assign read_word_o  = rw_q;
  assign pc_now_o     = pc_q;
  assign sp_now_o     = sp_q;
  assign idim_now_o   = idim_q;
  assign bad_opcode_o = bad_q;

  logic [31:0] off5, off4;
  logic [7:0]  fb;
  always_comb begin
    off5 = 32'({(op_q[4:0] & OffMask) ^ OffFlip, 2'b00});
    off4 = 32'({op_q[3:0] & AddspMask, 2'b00});
    case (pc_q[1:0])
      2'd0:    fb = mem_rd[31:24];
      2'd1:    fb = mem_rd[23:16];
      2'd2:    fb = mem_rd[15:8];
      default: fb = mem_rd[7:0];
    endcase
  end

  always_comb begin
    st_d = st_q; pc_d = pc_q; sp_d = sp_q; idim_d = idim_q; bad_d = bad_q;
    cmd_d = cmd_q; op_d = op_q; a_d = a_q; b_d = b_q; wa_d = wa_q;
    rw_d = rw_q; wr_d = wr_q; ok_d = ok_q;
    q_pop_o = 1'b0; we = 1'b0; ra = sp_q; wd = a_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1; cmd_d = q_cmd_i; bad_d = 1'b0;
          case (q_cmd_i.req)
            REQ_EXEC: begin
              ra = pc_q; st_d = ST_FETCH; ok_d = in_range(pc_q);
            end
            REQ_WRITE: begin
              wa_d = q_cmd_i.addr; a_d = q_cmd_i.wdata; wr_d = 1'b1;
              st_d = ST_TOS_W;
            end
            REQ_READ: begin
              ra = q_cmd_i.addr; ok_d = in_range(q_cmd_i.addr); st_d = ST_TOS;
            end
            default: begin
              pc_d = start_pc_i; sp_d = start_sp_i; idim_d = 1'b0;
              wr_d = 1'b0; st_d = ST_TOS_W;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // opcode byte available; read TOS next
        op_d = fb; ra = sp_q; ok_d = in_range(sp_q); st_d = ST_DEC;
      end
      ST_DEC: begin
        // mem_rd = word at sp (TOS)
        a_d = mem_rd; wr_d = 1'b0; st_d = ST_EXEC;
        if ((op_q & ImmBit) != 8'd0) st_d = ST_EXEC;
        else if (op_q[7:5] == 3'b010 || op_q[7:5] == 3'b011) begin
          ra = sp_q + off5; ok_d = in_range(ra); st_d = ST_RD1;
        end else if (op_q[7:4] == 4'b0001) begin
          ra = sp_q + off4; ok_d = in_range(ra); st_d = ST_RD1;
        end else if (op_q == OpAdd || op_q == OpAnd || op_q == OpOr ||
                     op_q == OpStore) begin
          ra = sp_q + 32'd4; ok_d = in_range(ra); st_d = ST_RD1;
        end else if (op_q == OpLoad) begin
          ra = mem_rd; ok_d = in_range(mem_rd); st_d = ST_RD1;
        end
      end
      ST_RD1: begin
        b_d = mem_rd; st_d = ST_EXEC;
      end
      ST_EXEC: begin
        st_d = ST_TOS_W; wr_d = 1'b1; wa_d = sp_q; idim_d = 1'b0;
        pc_d = pc_q + 32'd1;
        if ((op_q & ImmBit) != 8'd0) begin
          idim_d = 1'b1;
          if (idim_q) a_d = {a_q[24:0], op_q[6:0] & ImmMask};
          else begin
            a_d = {{25{op_q[6]}}, op_q[6:0] & ImmMask};
            wa_d = sp_q - 32'd4; sp_d = sp_q - 32'd4;
          end
        end else if (op_q[7:5] == 3'b010) begin
          wa_d = sp_q + off5; sp_d = sp_q + 32'd4;
        end else if (op_q[7:5] == 3'b011) begin
          a_d = b_q; wa_d = sp_q - 32'd4; sp_d = sp_q - 32'd4;
        end else if (op_q[7:5] == 3'b001) begin
          a_d = pc_q + 32'd1; wa_d = sp_q - 32'd4; sp_d = sp_q - 32'd4;
          pc_d = 32'(op_q[4:0] & OffMask) * 32'(EmuStride);
        end else if (op_q[7:4] == 4'b0001) begin
          a_d = a_q + b_q;
        end else begin
          case (op_q)
            OpPushsp: begin a_d = sp_q; wa_d = sp_q - 32'd4; sp_d = sp_q - 32'd4; end
            OpPoppc:  begin wr_d = 1'b0; pc_d = a_q; sp_d = sp_q + 32'd4; end
            OpAdd:    begin a_d = a_q + b_q; wa_d = sp_q + 32'd4; sp_d = sp_q + 32'd4; end
            OpAnd:    begin a_d = a_q & b_q; wa_d = sp_q + 32'd4; sp_d = sp_q + 32'd4; end
            OpOr:     begin a_d = a_q | b_q; wa_d = sp_q + 32'd4; sp_d = sp_q + 32'd4; end
            OpLoad:   a_d = b_q;
            OpNot:    a_d = ~a_q;
            OpFlip:   a_d = rev32(a_q);
            OpNop:    wr_d = 1'b0;
            OpStore:  begin a_d = b_q; wa_d = a_q; sp_d = sp_q + 32'd8; end
            OpPopsp:  begin wr_d = 1'b0; sp_d = a_q; end
            default: begin
              wr_d = 1'b0; bad_d = 1'b1; idim_d = idim_q;
            end
          endcase
        end
      end
      ST_TOS_W: begin
        // commit pending write, then read new TOS
        if (wr_q && in_range(wa_q)) begin
          we = 1'b1; ra = wa_q; wd = a_q;
        end
        wr_d = 1'b0; st_d = ST_TOS;
      end
      ST_TOS: begin
        if (cmd_q.req == REQ_READ) begin
          rw_d = mem_rd; st_d = ST_OUT;
        end else begin
          ra = sp_q; ok_d = in_range(sp_q); st_d = ST_RD2;
        end
      end
      ST_RD2: begin
        rw_d = mem_rd; st_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pc_q <= 32'd0; sp_q <= 32'd16376; idim_q <= 1'b0;
      bad_q <= 1'b0; wr_q <= 1'b0; ok_q <= 1'b0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; sp_q <= sp_d; idim_q <= idim_d;
      bad_q <= bad_d; wr_q <= wr_d; ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; op_q <= op_d; a_q <= a_d; b_q <= b_d;
    wa_q <= wa_d; rw_q <= rw_d;
  end
endmodule
`default_nettype wire

@@ hdl/stack_cpu_instruction_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Stack processor core with a private 4096-word big-endian memory. Each
// slave transaction is one request (execute one instruction, host word write,
// host word read, restart from start_pc/start_sp) and yields exactly one
// master transaction with the read/TOS word, pc, sp, immediate flag and an
// unsupported-opcode flag. A two-entry request queue decouples intake from
// the executor; a request is registered in it before it can be dequeued.
// The executor uses a single-port RAM with registered read, one access per
// cycle: an instruction goes through fetch, TOS read, optional operand read,
// compute, write and TOS re-read, a host read through one read, a host write
// or restart through the write state and TOS re-read. The result is then held
// until the master handshake; the next dequeue waits for the return to idle.
// Memory contents are undefined until written; no clearing pass is done.
module stack_cpu_instruction_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] host_addr, [63:32] host_wdata
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // [31:0] read_word, [63:32] pc_now,
                                          // [95:64] sp_now
  output logic [1:0]       m_axis_tuser,  // [0] idim_now, [1] bad_opcode
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import scis_pkg::*;

  localparam logic [2:0] AddrStartPc = 3'd0;
  localparam logic [2:0] AddrStartSp = 3'd4;

  logic [31:0] start_pc_q, start_sp_q;
  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_pop;
  logic [31:0] rw, pcn, spn;
  logic        idim, bad;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= 32'd0;
      start_sp_q <= 32'd16376;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrStartPc) start_pc_q <= pwdata;
      if (paddr == AddrStartSp) start_sp_q <= pwdata;
    end
  end

  always_comb begin
    case (paddr)
      AddrStartPc: prdata = start_pc_q;
      AddrStartSp: prdata = start_sp_q;
      default:     prdata = 32'd0;
    endcase
  end

  assign in_cmd.req   = req_e'(s_axis_tuser);
  assign in_cmd.addr  = s_axis_tdata[31:0];
  assign in_cmd.wdata = s_axis_tdata[63:32];

  scis_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  scis_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .start_pc_i(start_pc_q), .start_sp_i(start_sp_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .read_word_o(rw), .pc_now_o(pcn), .sp_now_o(spn),
    .idim_now_o(idim), .bad_opcode_o(bad)
  );

  assign m_axis_tdata = {spn, pcn, rw};
  assign m_axis_tuser = {bad, idim};

`ifndef SYNTHESIS
  // a new result must follow a dequeue by the latency of a read, a write or restart, or an execute
  a_out_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(q_pop, 2) || $past(q_pop, 4) ||
    $past(q_pop, 7) || $past(q_pop, 8)) else $error("result without request");
  // no request leaves the queue while a result with the bad-opcode flag waits
  a_bad_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !q_pop) else $error("pop while result pending");
`endif
endmodule
`default_nettype wire

@@ tb/stack_cpu_checker.sv @@
`timescale 1ns / 1ps
module stack_cpu_checker
  import scis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          bad_seen_o
);

  localparam logic [2:0] RegStartPc = 3'd0;
  localparam logic [2:0] RegStartSp = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] pc;
    logic [31:0] sp;
    logic        imm;
    logic        bad;
  } step_res_t;

  logic [31:0] mem_q [MemWords];
  logic [31:0] cpu_pc, cpu_sp, boot_pc, boot_sp;
  logic        cpu_imm;
  step_res_t   pending_q [$];

  assign pending_o = pending_q.size();

  function automatic logic hit(input logic [31:0] a);
    return {32'd0, a} < 64'(MemWords) * 64'd4;
  endfunction

  function automatic logic [31:0] mem_rd(input logic [31:0] a);
    return hit(a) ? mem_q[a >> 2] : 32'd0;
  endfunction

  task automatic mem_wr(input logic [31:0] a, input logic [31:0] v);
    if (hit(a)) mem_q[a >> 2] = v;
  endtask

  task automatic pop_word(output logic [31:0] v);
    v = mem_rd(cpu_sp);
    cpu_sp += 32'd4;
  endtask

  task automatic push_word(input logic [31:0] v);
    cpu_sp -= 32'd4;
    mem_wr(cpu_sp, v);
  endtask

  // One instruction; returns 1 for an unsupported opcode.
  task automatic run_instr(output logic bad);
    logic [31:0] w, a, b;
    logic [7:0]  op;
    w   = mem_rd(cpu_pc);
    op  = 8'(w >> ((3 - cpu_pc[1:0]) * 8));
    bad = 1'b0;
    if (op[7]) begin
      if (cpu_imm) begin
        b = mem_rd(cpu_sp);
        mem_wr(cpu_sp, {b[24:0], op[6:0]});
      end else begin
        push_word({{25{op[6]}}, op[6:0]});
      end
      cpu_imm = 1'b1;
      cpu_pc += 32'd1;
    end else if (op[7:5] == 3'b001) begin  // emulate: call into vector table
      push_word(cpu_pc + 32'd1);
      cpu_imm = 1'b0;
      cpu_pc  = 32'(op[4:0]) * 32'd32;
    end else if (op == OpPoppc) begin
      pop_word(a);
      cpu_imm = 1'b0;
      cpu_pc  = a;
    end else begin
      if (op[7:5] == 3'b010) begin
        a = cpu_sp + 32'({op[4:0] ^ 5'h10}) * 32'd4;
        pop_word(b);
        mem_wr(a, b);
      end else if (op[7:5] == 3'b011) begin
        a = cpu_sp + 32'({op[4:0] ^ 5'h10}) * 32'd4;
        push_word(mem_rd(a));
      end else if (op[7:4] == 4'b0001) begin
        a = mem_rd(cpu_sp + 32'(op[3:0]) * 32'd4);
        mem_wr(cpu_sp, a + mem_rd(cpu_sp));
      end else if (op == OpPushsp) begin
        push_word(cpu_sp);
      end else if (op == OpAdd || op == OpAnd || op == OpOr) begin
        pop_word(a);
        b = mem_rd(cpu_sp);
        mem_wr(cpu_sp, op == OpAdd ? a + b : op == OpAnd ? a & b : a | b);
      end else if (op == OpLoad) begin
        mem_wr(cpu_sp, mem_rd(mem_rd(cpu_sp)));
      end else if (op == OpNot) begin
        mem_wr(cpu_sp, ~mem_rd(cpu_sp));
      end else if (op == OpFlip) begin
        a = mem_rd(cpu_sp);
        for (int i = 0; i < 32; i++) b[i] = a[31-i];
        mem_wr(cpu_sp, b);
      end else if (op == OpNop) begin
      end else if (op == OpStore) begin
        pop_word(a);
        pop_word(b);
        mem_wr(a, b);
      end else if (op == OpPopsp) begin
        pop_word(a);
        cpu_sp = a;
      end else begin
        bad = 1'b1;
      end
      if (!bad) cpu_imm = 1'b0;
      cpu_pc += 32'd1;
    end
  endtask

  task automatic predict_step(input req_e r, input logic [31:0] a, input logic [31:0] d);
    step_res_t e;
    e.bad = 1'b0;
    case (r)
      REQ_EXEC: begin
        run_instr(e.bad);
        e.word = mem_rd(cpu_sp);
      end
      REQ_WRITE: begin
        mem_wr(a, d);
        e.word = mem_rd(cpu_sp);
      end
      REQ_READ: e.word = mem_rd(a);
      default: begin
        cpu_pc  = boot_pc;
        cpu_sp  = boot_sp;
        cpu_imm = 1'b0;
        e.word  = mem_rd(cpu_sp);
      end
    endcase
    e.pc  = cpu_pc;
    e.sp  = cpu_sp;
    e.imm = cpu_imm;
    pending_q.push_back(e);
  endtask

  task automatic report(input string what, input logic [31:0] exp, input logic [31:0] act);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch %s: expected %h got %h (result %0d)", what, exp, act, checked_o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t e;
    if (!rst_ni) begin
      foreach (mem_q[i]) mem_q[i] = '0;
      boot_pc = 32'd0;
      boot_sp = 32'd16376;
      cpu_pc  = boot_pc;
      cpu_sp  = boot_sp;
      cpu_imm = 1'b0;
      pending_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      bad_seen_o   = 0;
    end else begin
      // results first: a result never belongs to a request taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          report("unexpected transaction", 32'd0, m_axis_tdata[31:0]);
        end else begin
          e = pending_q.pop_front();
          if (m_axis_tdata[31:0] !== e.word) report("read_word", e.word, m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] !== e.pc) report("pc_now", e.pc, m_axis_tdata[63:32]);
          if (m_axis_tdata[95:64] !== e.sp) report("sp_now", e.sp, m_axis_tdata[95:64]);
          if (m_axis_tuser[0] !== e.imm) report("idim_now", 32'(e.imm), 32'(m_axis_tuser[0]));
          if (m_axis_tuser[1] !== e.bad) report("bad_opcode", 32'(e.bad), 32'(m_axis_tuser[1]));
          if (e.bad) bad_seen_o++;
        end
        checked_o++;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_step(req_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (psel && penable && pwrite && pready) begin
        if (paddr == RegStartPc) boot_pc = pwdata;
        else if (paddr == RegStartSp) boot_sp = pwdata;
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import scis_pkg::*;

  localparam logic [2:0] RegStartPc = 3'd0;
  localparam logic [2:0] RegStartSp = 3'd4;
  localparam int StallLimit   = 2000;  // cycles with no transaction on either side
  localparam int RandomItems  = 1950;
  localparam int DrainCycles  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] host_addr, [63:32] host_wdata
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // [31:0] read_word, [63:32] pc_now, [95:64] sp_now
  logic [1:0]  m_axis_tuser;        // [0] idim_now, [1] bad_opcode
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, checked, bad_seen;
  int sent = 0;
  int settings = 1;
  bit steady = 1'b0;  // when set neither side inserts bubbles

  stack_cpu_instruction_step dut (.*);

  stack_cpu_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .bad_seen_o(bad_seen)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Result side backpressure: ~21% of cycles stalled unless in the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Watchdog: give up if nothing moves for too long.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Send one request transaction. tvalid stays high between back-to-back
  // requests so it is never dropped and raised on the same edge.
  task automatic send(input req_e r, input logic [31:0] a, input logic [31:0] d);
    if (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r;
    s_axis_tdata  <= {d, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Lower valid, let every outstanding result arrive, then a short settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Opcode byte, weighted toward the supported classes.
  function automatic logic [7:0] rand_op();
    logic [7:0] odd [5] = '{8'h00, 8'h01, 8'h03, 8'h0E, 8'h0F};
    case ($urandom_range(9))
      0, 1:    return 8'h80 | 8'($urandom_range(127));
      2:       return 8'h40 | 8'($urandom_range(31));
      3:       return 8'h60 | 8'($urandom_range(31));
      4:       return 8'h20 | 8'($urandom_range(31));
      5:       return 8'h10 | 8'($urandom_range(15));
      9:       return odd[$urandom_range(4)];
      default: return 8'($urandom_range(8'h02, 8'h0D));
    endcase
  endfunction

  // Drop a random program at the boot pc, restart, and run it with
  // host traffic sprinkled in.
  task automatic run_program(input logic [31:0] boot, input int steps);
    logic [31:0] a;
    for (int i = 0; i < 6; i++)
      send(REQ_WRITE, boot + 32'(i * 4), {rand_op(), rand_op(), rand_op(), rand_op()});
    send(REQ_START, $urandom, $urandom);
    for (int i = 0; i < steps; i++) begin
      // a long stretch without bubbles in the second quarter of every phase
      steady = (i >= steps / 4 && i < steps / 2);
      case ($urandom_range(99)) inside
        [0:7]: begin
          a = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(MemWords * 4 - 1));
          send(REQ_WRITE, a, $urandom);
        end
        [8:12]: begin
          a = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(MemWords * 4 - 1));
          send(REQ_READ, a, $urandom);
        end
        [13:15]: send(REQ_START, $urandom, $urandom);
        default: send(REQ_EXEC, $urandom, $urandom);
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [31:0] boot_pc [6] = '{32'd0, 32'h0000_0100, 32'hFFFF_FFFC, 32'h0000_3FFC,
                                 32'h0000_2000, 32'h0000_0040};
    logic [31:0] boot_sp [6] = '{32'd16376, 32'h0000_3FFC, 32'h0000_0000, 32'hFFFF_FFFF,
                                 32'h0000_1002, 32'h0000_0800};
    logic [31:0] words [5] = '{32'hBFC0FF02, 32'h05060709, 32'h0A0B0170,
                               32'h5011080C, 32'h0D043F00};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Memory is undefined until written, so fill all of it first.
    for (int i = 0; i < MemWords; i++) send(REQ_WRITE, 32'(i * 4), $urandom);

    // Directed: a fixed program from pc 0 that runs every instruction class but emulate.
    foreach (words[i]) send(REQ_WRITE, 32'(i * 4), words[i]);
    send(REQ_START, 32'd0, 32'd0);
    repeat (18) send(REQ_EXEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_READ, 32'hFFFF_FFFC, 32'd0);             // far beyond memory
    send(REQ_READ, 32'(MemWords * 4), 32'd0);         // first word past the end
    send(REQ_WRITE, 32'(MemWords * 4), 32'hDEAD_BEEF); // dropped
    send(REQ_READ, 32'(MemWords * 4 - 1), 32'd0);     // unaligned, last word
    send(REQ_READ, 32'd3, 32'd0);

    // Random phases, each from its own boot pc/sp pair.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        drain();  // the core must be idle before reconfiguring
        apb_write(RegStartPc, boot_pc[ph]);
        apb_write(RegStartSp, boot_sp[ph]);
        settings++;
      end
      run_program(boot_pc[ph], RandomItems / 6);
    end

    drain();
    $display("covered %0d requests and %0d results (%0d unsupported opcodes) over %0d",
             sent, checked, bad_seen, settings);
    $display("boot pc/sp settings, full memory preload included");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
